// ----- src/fbe_pkg.sv -----
// Package for the feedback echo: register indexes, fixed field widths, state and handshake types.
`default_nettype none

package fbe_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_FRAMES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_GAIN      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

   // Register widths.
   localparam int DELAY_W    = 18;
   localparam int FEEDBACK_W = 15;
   localparam int MIX_W      = 16;
   localparam int CHCOUNT_W  = 2;

   // Q15 arithmetic.
   localparam int Q_SHIFT    = 15;
   localparam int ROUND_HALF = 16384;
   localparam int UNITY      = 32768;
   localparam int GAIN_W     = 17;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WET,
      ST_MIX,
      ST_DONE,
      ST_CLR_RSP
   } fbe_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic wet;
      logic mix;
      logic finish;
      logic clr_rsp;
      logic clr_step;
   } fbe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic sweep_last;
   } fbe_status_type;

endpackage

`default_nettype wire

// ----- src/fbe_if.sv -----
// Handshake interfaces for the sample channel and the result channel.
`default_nettype none

interface fbe_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] in_sample;
   logic                          block_end;

   modport source (output valid, action, in_sample, block_end, input ready);
   modport sink   (input valid, action, in_sample, block_end, output ready);
endinterface

interface fbe_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          out_channel;
   logic                          clipped;
   logic                          last;

   modport source (output valid, out_sample, out_channel, clipped, last, input ready);
   modport sink   (input valid, out_sample, out_channel, clipped, last, output ready);
endinterface

`default_nettype wire

// ----- src/fbe_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fbe_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/fbe_ctrl.sv -----
// Controller state machine: sequences one word through the datapath and runs the clearing sweep.
`default_nettype none

module fbe_ctrl
   import fbe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_action,
   output      logic           req_ready,
   input  wire fbe_status_type status,
   output      fbe_cmd_type    cmd
);

   fbe_state_type state_ff;
   fbe_state_type state_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = req_action ? ST_CLR_RSP : ST_MUL;
         end
         ST_MUL:  state_in = ST_WET;
         ST_WET:  state_in = ST_MIX;
         ST_MIX:  state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_CLR_RSP: begin
            if (status.out_free) state_in = ST_CLEAR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:   cmd.clr_step = 1'b1;
         ST_IDLE:    cmd.load     = accept;
         ST_MUL:     cmd.mul      = 1'b1;
         ST_WET:     cmd.wet      = 1'b1;
         ST_MIX:     cmd.mix      = 1'b1;
         ST_DONE:    cmd.finish   = status.out_free;
         ST_CLR_RSP: cmd.clr_rsp  = status.out_free;
         default:    cmd          = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/fbe_datapath.sv -----
// Datapath: settings, positions, feedback and mix arithmetic, and the result word register.
`default_nettype none

module fbe_datapath
   import fbe_pkg::*;
#(
   parameter int MAX_DELAY_FRAMES = 131072,
   parameter int MAX_CHANNELS     = 2,
   parameter int SAMPLE_BITS      = 16,
   parameter int DEPTH            = MAX_DELAY_FRAMES * MAX_CHANNELS,
   parameter int STORE_W          = SAMPLE_BITS + 4,
   parameter int ADDR_W           = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fbe_cmd_type                   cmd,
   output      fbe_status_type                status,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0] req_in_sample,
   input  wire logic                          req_block_end,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_valid,
   output      logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output      logic                          rsp_out_channel,
   output      logic                          rsp_clipped,
   output      logic                          rsp_last,
   output      logic                          ram_we,
   output      logic [ADDR_W-1:0]             ram_waddr,
   output      logic [STORE_W-1:0]            ram_wdata,
   output      logic                          ram_re,
   output      logic [ADDR_W-1:0]             ram_raddr,
   input  wire logic [STORE_W-1:0]            ram_rdata
);

   localparam int FRAME_W = $clog2(MAX_DELAY_FRAMES);
   localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DL_W    = $clog2(MAX_DELAY_FRAMES + 1);
   localparam int CC_W    = $clog2(MAX_CHANNELS + 1);
   localparam int P1_W    = STORE_W + 16;
   localparam int W1_W    = P1_W - Q_SHIFT;
   localparam int WF_W    = STORE_W + 2;
   localparam int DP_W    = SAMPLE_BITS + GAIN_W + 1;
   localparam int WP_W    = STORE_W + GAIN_W + 1;
   localparam int S_W     = STORE_W + GAIN_W + 2;
   localparam int O_W     = S_W - Q_SHIFT;

   // Settings.
   logic [DELAY_W-1:0]    delay_ff;
   logic [FEEDBACK_W-1:0] feedback_ff;
   logic [MIX_W-1:0]      mix_ff;
   logic [CHCOUNT_W-1:0]  chcount_ff;

   // Positions and sweep address.
   logic [FRAME_W-1:0] frame_ff;
   logic [FRAME_W-1:0] frame_in;
   logic [CH_W-1:0]    chan_ff;
   logic [CH_W-1:0]    chan_in;
   logic [ADDR_W-1:0]  sweep_ff;

   // Per-word working registers.
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic                          last_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic signed [P1_W-1:0]        prod_ff;
   logic signed [STORE_W-1:0]     wet_ff;
   logic                          hit_ff;
   logic signed [DP_W-1:0]        dryp_ff;
   logic signed [S_W-1:0]         sum_ff;

   // Result word register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_channel_ff;
   logic                          clipped_ff;
   logic                          last_out_ff;

   logic [DL_W-1:0]            dl_eff;
   logic [DL_W-1:0]            frame_plus;
   logic [CC_W-1:0]            cc_eff;
   logic [CC_W-1:0]            chan_plus;
   logic [ADDR_W-1:0]          addr_now;
   logic [GAIN_W-1:0]          mx_eff;
   logic [GAIN_W-1:0]          umx;
   logic [P1_W-1:0]            prod_rnd;
   logic signed [W1_W-1:0]     fb_term;
   logic signed [WF_W-1:0]     wet_full;
   logic signed [STORE_W-1:0]  wet_sat;
   logic                       wet_hit;
   logic signed [WP_W-1:0]     wetp;
   logic [S_W-1:0]             sum_rnd;
   logic signed [O_W-1:0]      o_full;
   logic signed [SAMPLE_BITS-1:0] o_sat;
   logic                       o_hit;

   // Effective settings after clamping.
   always_comb begin
      if (32'(delay_ff) > 32'(MAX_DELAY_FRAMES)) begin
         dl_eff = DL_W'(MAX_DELAY_FRAMES);
      end else if (delay_ff == '0) begin
         dl_eff = DL_W'(1);
      end else begin
         dl_eff = DL_W'(delay_ff);
      end

      if (32'(chcount_ff) > 32'(MAX_CHANNELS)) begin
         cc_eff = CC_W'(MAX_CHANNELS);
      end else if (chcount_ff == '0) begin
         cc_eff = CC_W'(1);
      end else begin
         cc_eff = CC_W'(chcount_ff);
      end

      mx_eff = (32'(mix_ff) > UNITY) ? GAIN_W'(UNITY) : GAIN_W'(mix_ff);
      umx    = GAIN_W'(UNITY) - mx_eff;
   end

   // Position advance after the word's result is taken into the output register.
   always_comb begin
      frame_plus = DL_W'(frame_ff) + DL_W'(1);
      chan_plus  = CC_W'(chan_ff) + CC_W'(1);
      frame_in   = frame_ff;
      chan_in    = chan_ff;
      if (chan_plus >= cc_eff) begin
         chan_in  = '0;
         frame_in = (frame_plus >= dl_eff) ? '0 : frame_plus[FRAME_W-1:0];
      end else begin
         chan_in = chan_plus[CH_W-1:0];
      end
   end

   assign addr_now = ADDR_W'(frame_ff) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(chan_ff);

   // Wet value: dry plus rounded feedback term, saturated to the store's range.
   always_comb begin
      prod_rnd = prod_ff + P1_W'(ROUND_HALF);
      fb_term  = $signed(prod_rnd[P1_W-1:Q_SHIFT]);
      wet_full = WF_W'(dry_ff) + WF_W'(fb_term);
      wet_hit  = !((&wet_full[WF_W-1:STORE_W-1]) || !(|wet_full[WF_W-1:STORE_W-1]));
      if (wet_hit) begin
         wet_sat = {wet_full[WF_W-1], {(STORE_W-1){~wet_full[WF_W-1]}}};
      end else begin
         wet_sat = wet_full[STORE_W-1:0];
      end
   end

   assign wetp = wet_ff * $signed({1'b0, mx_eff});

   // Output: rounded mix, clipped to the sample's full scale.
   always_comb begin
      sum_rnd = sum_ff + S_W'(ROUND_HALF);
      o_full  = $signed(sum_rnd[S_W-1:Q_SHIFT]);
      o_hit   = !((&o_full[O_W-1:SAMPLE_BITS-1]) || !(|o_full[O_W-1:SAMPLE_BITS-1]));
      if (o_hit) begin
         o_sat = {o_full[O_W-1], {(SAMPLE_BITS-1){~o_full[O_W-1]}}};
      end else begin
         o_sat = o_full[SAMPLE_BITS-1:0];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_W'(1);
         feedback_ff <= '0;
         mix_ff      <= '0;
         chcount_ff  <= CHCOUNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_DELAY_FRAMES:  delay_ff    <= csr_wdata[DELAY_W-1:0];
            REG_FEEDBACK_GAIN: feedback_ff <= csr_wdata[FEEDBACK_W-1:0];
            REG_MIX_GAIN:      mix_ff      <= csr_wdata[MIX_W-1:0];
            REG_CHANNEL_COUNT: chcount_ff  <= csr_wdata[CHCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Positions and clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         chan_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         if (cmd.clr_rsp) begin
            frame_ff <= '0;
            chan_ff  <= '0;
         end else if (cmd.finish) begin
            frame_ff <= frame_in;
            chan_ff  <= chan_in;
         end
         if (cmd.clr_step) begin
            sweep_ff <= status.sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
      end
   end

   // Working registers of the word in flight.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dry_ff  <= req_in_sample;
         last_ff <= req_block_end;
         addr_ff <= addr_now;
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, feedback_ff}) * $signed(ram_rdata);
      end
      if (cmd.wet) begin
         wet_ff  <= wet_sat;
         hit_ff  <= wet_hit;
         dryp_ff <= dry_ff * $signed({1'b0, umx});
      end
      if (cmd.mix) begin
         sum_ff <= S_W'(dryp_ff) + S_W'(wetp);
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish || cmd.clr_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_sample_ff  <= o_sat;
         out_channel_ff <= chan_ff[0];
         clipped_ff     <= hit_ff || o_hit;
         last_out_ff    <= last_ff;
      end else if (cmd.clr_rsp) begin
         out_sample_ff  <= '0;
         out_channel_ff <= 1'b0;
         clipped_ff     <= 1'b0;
         last_out_ff    <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = out_sample_ff;
   assign rsp_out_channel = out_channel_ff;
   assign rsp_clipped     = clipped_ff;
   assign rsp_last        = last_out_ff;

   // The delay store is written with the wet value, or with zero during the sweep.
   assign ram_re    = cmd.load;
   assign ram_raddr = addr_now;
   assign ram_we    = cmd.wet || cmd.clr_step;
   assign ram_waddr = cmd.clr_step ? sweep_ff : addr_ff;
   assign ram_wdata = cmd.clr_step ? '0 : wet_sat;

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.sweep_last = (sweep_ff == ADDR_W'(DEPTH - 1));

endmodule

`default_nettype wire

// ----- src/feedback_echo_delay_top.sv -----
// A sample word passes through the delay memory read, the feedback multiply, the wet write-back,
// the mix multiply and the result register load; the load waits until the output register is
// free, and a new word is accepted only once the last one is done.
// A clear word's result is loaded once the output register is free, then the delay memory is
// zeroed one entry a cycle, MAX_DELAY_FRAMES * MAX_CHANNELS entries (262144 by default).
// Reset is synchronous and active high; it starts the same zeroing pass and restores the settings
// to one frame of delay, no feedback, no wet mix and one channel. Settings writes are taken always.
`default_nettype none

module feedback_echo_delay_top
   import fbe_pkg::*;
#(
   parameter int MAX_DELAY_FRAMES = 131072,
   parameter int MAX_CHANNELS     = 2,
   parameter int SAMPLE_BITS      = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   fbe_req_if.sink                     req_if,
   fbe_rsp_if.source                   rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH   = MAX_DELAY_FRAMES * MAX_CHANNELS;
   localparam int STORE_W = SAMPLE_BITS + 4;
   localparam int ADDR_W  = $clog2(DEPTH);

   fbe_cmd_type    cmd;
   fbe_status_type status;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [STORE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [STORE_W-1:0] ram_rdata;

   fbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .status     (status),
      .cmd        (cmd)
   );

   fbe_datapath #(
      .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
      .MAX_CHANNELS     (MAX_CHANNELS),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .DEPTH            (DEPTH),
      .STORE_W          (STORE_W),
      .ADDR_W           (ADDR_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_in_sample   (req_if.in_sample),
      .req_block_end   (req_if.block_end),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_out_sample  (rsp_if.out_sample),
      .rsp_out_channel (rsp_if.out_channel),
      .rsp_clipped     (rsp_if.clipped),
      .rsp_last        (rsp_if.last),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata)
   );

   fbe_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_delay_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

`ifndef ASSERT_OFF
   // Only one word is in flight: acceptance closes the input until the word is done.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("word accepted while another is in flight");

   // No word is taken while the delay memory is being zeroed.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_if.ready)
      else $error("input ready during clearing sweep");

   // A result is only loaded into a free output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.clr_rsp) |-> status.out_free)
      else $error("result word overwritten before it was taken");

   // A result word appears only after the controller has loaded one.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.finish || cmd.clr_rsp))
      else $error("result valid without a load");
`endif

endmodule

`default_nettype wire

// ----- tb/fbe_tb_pkg.sv -----
// Checking package for the feedback echo bench: constants, result record and echo scoreboard.
package fbe_tb_pkg;
   import fbe_pkg::*;

   localparam int SAMPLE_W       = 16;
   localparam int STORE_W        = SAMPLE_W + 4;
   localparam int DELAY_DEPTH    = 131072;
   localparam int CHANNEL_LIMIT  = 2;
   localparam int FEEDBACK_LIMIT = 31130;

   localparam longint SAMPLE_MAX = 32767;
   localparam longint SAMPLE_MIN = -32768;
   localparam longint STORE_MAX  = 524287;
   localparam longint STORE_MIN  = -524288;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel;
      logic                       clipped;
      logic                       last;
   } echo_result_type;

   class echo_scoreboard;
      logic signed [STORE_W-1:0] delay_line [int unsigned];
      int unsigned               frame_pos;
      int unsigned               chan_pos;
      logic [DELAY_W-1:0]        delay_frames;
      logic [FEEDBACK_W-1:0]     feedback;
      logic [MIX_W-1:0]          mix;
      logic [CHCOUNT_W-1:0]      channels;
      echo_result_type           pending_q [$];
      int                        mismatches;
      int                        checked;
      int                        samples;
      int                        clears;

      function new();
         frame_pos    = 0;
         chan_pos     = 0;
         delay_frames = 1;
         feedback     = 0;
         mix          = 0;
         channels     = 1;
         mismatches   = 0;
         checked      = 0;
         samples      = 0;
         clears       = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_DELAY_FRAMES:  delay_frames = value[DELAY_W-1:0];
            REG_FEEDBACK_GAIN: feedback     = value[FEEDBACK_W-1:0];
            REG_MIX_GAIN:      mix          = value[MIX_W-1:0];
            REG_CHANNEL_COUNT: channels     = value[CHCOUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Round half up: add half an LSB, then floor the shift.
      function longint round_q15(longint v);
         return (v + ROUND_HALF) >>> Q_SHIFT;
      endfunction

      function longint clamp(longint v, longint lo, longint hi, inout bit hit);
         if (v > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (v < lo) begin
            hit = 1'b1;
            return lo;
         end
         return v;
      endfunction

      function void note_word(logic action, logic signed [SAMPLE_W-1:0] dry, logic block_end);
         echo_result_type due;
         longint          span;
         longint          count;
         longint          wet_gain;
         longint          held;
         longint          wet;
         longint          mixed;
         int unsigned     ch;
         int unsigned     addr;
         bit              hit;
         due.last = block_end;
         if (action == ACT_CLEAR) begin
            delay_line.delete();
            frame_pos   = 0;
            chan_pos    = 0;
            due.sample  = '0;
            due.channel = 1'b0;
            due.clipped = 1'b0;
            clears++;
         end else begin
            // Out-of-range settings are folded into range before use.
            span = delay_frames;
            if (span == 0) span = 1;
            if (span > DELAY_DEPTH) span = DELAY_DEPTH;
            count = channels;
            if (count == 0) count = 1;
            if (count > CHANNEL_LIMIT) count = CHANNEL_LIMIT;
            wet_gain = mix;
            if (wet_gain > UNITY) wet_gain = UNITY;

            ch   = chan_pos % CHANNEL_LIMIT;
            addr = (frame_pos % DELAY_DEPTH) * CHANNEL_LIMIT + ch;
            held = delay_line.exists(addr) ? longint'(delay_line[addr]) : 0;
            hit  = 1'b0;
            wet  = clamp(longint'(dry) + round_q15(longint'(feedback) * held),
                         STORE_MIN, STORE_MAX, hit);
            delay_line[addr] = STORE_W'(wet);
            mixed = round_q15(longint'(dry) * (UNITY - wet_gain) + wet * wet_gain);
            mixed = clamp(mixed, SAMPLE_MIN, SAMPLE_MAX, hit);

            due.sample  = SAMPLE_W'(mixed);
            due.channel = ch[0];
            due.clipped = hit;

            // A channel position left beyond a reduced count closes the frame at once.
            if (ch + 1 >= count) begin
               chan_pos  = 0;
               frame_pos = (frame_pos + 1 >= span) ? 0 : frame_pos + 1;
            end else begin
               chan_pos = ch + 1;
            end
            samples++;
         end
         pending_q.push_back(due);
      endfunction

      function void check_word(echo_result_type got);
         echo_result_type due;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: sample %0d channel %0b clipped %0b last %0b",
                        got.sample, got.channel, got.clipped, got.last);
         end else begin
            due = pending_q.pop_front();
            checked++;
            if (got.sample !== due.sample || got.channel !== due.channel ||
                got.clipped !== due.clipped || got.last !== due.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Result %0d wrong: expected sample %0d ch %0b clip %0b last %0b,",
                            " got sample %0d ch %0b clip %0b last %0b"},
                           checked, due.sample, due.channel, due.clipped, due.last,
                           got.sample, got.channel, got.clipped, got.last);
            end
         end
      endfunction
   endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level bench for the feedback echo: clock, reset, drivers, monitors and the run sequence.
module tb_top;
   import fbe_pkg::*;
   import fbe_tb_pkg::*;

   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 20;
   localparam int PHASES          = 16;
   localparam int WORDS_PER_PHASE = 100;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit sender_steady;
   bit receiver_steady;
   int hold_left;

   echo_scoreboard sb = new();

   fbe_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   fbe_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_bus ();

   feedback_echo_delay_top #(
      .MAX_DELAY_FRAMES(DELAY_DEPTH),
      .MAX_CHANNELS(CHANNEL_LIMIT),
      .SAMPLE_BITS(SAMPLE_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_W'(SAMPLE_MAX);
         1: return SAMPLE_W'(SAMPLE_MIN);
         2: return SAMPLE_W'($signed($urandom_range(0, 63)) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Valid is left high after acceptance so that back-to-back words need no re-raise.
   task automatic send_word(logic action, logic signed [SAMPLE_W-1:0] dry, logic block_end);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= action;
      req_bus.in_sample <= dry;
      req_bus.block_end <= block_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_settings(logic [CSR_DATA_W-1:0] frames, logic [CSR_DATA_W-1:0] fb_gain,
                                 logic [CSR_DATA_W-1:0] wet_mix, logic [CSR_DATA_W-1:0] chans);
      logic [CSR_INDEX_W-1:0] order [4];
      logic [CSR_DATA_W-1:0]  value [4];
      order = '{REG_DELAY_FRAMES, REG_FEEDBACK_GAIN, REG_MIX_GAIN, REG_CHANNEL_COUNT};
      value = '{frames, fb_gain, wet_mix, chans};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= value[i];
         @(posedge clock);
         sb.write_register(order[i], value[i]);
      end
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : word_monitor
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
         sb.note_word(req_bus.action, req_bus.in_sample, req_bus.block_end);
   end

   always @(posedge clock) begin : result_monitor
      echo_result_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.sample  = rsp_bus.out_sample;
         got.channel = rsp_bus.out_channel;
         got.clipped = rsp_bus.clipped;
         got.last    = rsp_bus.last;
         sb.check_word(got);
      end
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!receiver_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] frames;
      logic [CSR_DATA_W-1:0] fb_gain;
      logic [CSR_DATA_W-1:0] wet_mix;
      logic [CSR_DATA_W-1:0] chans;
      int                    errors;
      req_bus.valid     <= 1'b0;
      req_bus.action    <= ACT_SAMPLE;
      req_bus.in_sample <= '0;
      req_bus.block_end <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= REG_DELAY_FRAMES;
      csr_wdata         <= '0;
      reset             <= 1'b1;
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      hold_left       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Plain pass-through at the reset settings, full-scale and zero-crossing words.
      write_settings(18'd1, 18'd0, 18'd0, 18'd1);
      send_word(ACT_SAMPLE, SAMPLE_W'(SAMPLE_MAX), 1'b0);
      send_word(ACT_SAMPLE, SAMPLE_W'(SAMPLE_MIN), 1'b1);
      send_word(ACT_SAMPLE, '0, 1'b0);
      send_word(ACT_SAMPLE, '1, 1'b1);
      wait_drained();

      // Zero delay, zero channels, mix above unity and maximum feedback: a run of
      // full-scale words drives the stored wet value into saturation.
      write_settings(18'd0, 18'h7FFF, 18'hFFFF, 18'd0);
      for (int i = 0; i < 17; i++)
         send_word(ACT_SAMPLE, SAMPLE_W'(SAMPLE_MAX), i[0]);
      send_word(ACT_SAMPLE, SAMPLE_W'(SAMPLE_MIN), 1'b0);
      send_word(ACT_SAMPLE, SAMPLE_W'(SAMPLE_MIN), 1'b1);
      send_word(ACT_CLEAR, pick_sample(), 1'b1);
      send_word(ACT_SAMPLE, SAMPLE_W'(1000), 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p == 0) begin
            frames  = CSR_DATA_W'(DELAY_DEPTH);
            fb_gain = CSR_DATA_W'(FEEDBACK_LIMIT);
            wet_mix = CSR_DATA_W'(UNITY);
            chans   = CSR_DATA_W'(CHANNEL_LIMIT);
         end else if (p == 1) begin
            frames  = 18'h3FFFF;
            fb_gain = 18'h7FFF;
            wet_mix = 18'hFFFF;
            chans   = 18'd3;
         end else begin
            case ($urandom_range(0, 9))
               0: frames = '0;
               1: frames = CSR_DATA_W'(DELAY_DEPTH);
               2: frames = 18'h3FFFF;
               3: frames = CSR_DATA_W'($urandom_range(100, 2000));
               default: frames = CSR_DATA_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 4))
               0: fb_gain = '0;
               1: fb_gain = 18'h7FFF;
               2: fb_gain = CSR_DATA_W'(FEEDBACK_LIMIT);
               default: fb_gain = CSR_DATA_W'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 4))
               0: wet_mix = '0;
               1: wet_mix = CSR_DATA_W'(UNITY);
               2: wet_mix = 18'hFFFF;
               default: wet_mix = CSR_DATA_W'($urandom_range(0, UNITY));
            endcase
            chans = CSR_DATA_W'($urandom_range(0, 3));
         end
         // Positions are deliberately carried over from the previous settings.
         write_settings(frames, fb_gain, wet_mix, chans);
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         if (p == PHASES / 2) send_word(ACT_CLEAR, pick_sample(), 1'($urandom));
         if (p == 4) begin
            // The result side stops for a long stretch while words keep coming.
            sender_steady = 1'b1;
            hold_left     = HOLD_CYCLES;
         end
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (p == 6 && i == WORDS_PER_PHASE / 2) wait_drained();
            send_word(ACT_SAMPLE, pick_sample(), $urandom_range(0, 7) == 0);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      errors = sb.mismatches + sb.pending();
      $display("Covered %0d sample words and %0d clears over %0d settings, %0d results checked.",
               sb.samples, sb.clears, PHASES + 2, sb.checked);
      $display("Included a %0d-cycle result stall with input backed up and a mid-phase drain.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/fbe_pkg.sv
src/fbe_if.sv
src/fbe_ram.sv
src/fbe_ctrl.sv
src/fbe_datapath.sv
src/feedback_echo_delay_top.sv
tb/fbe_tb_pkg.sv
tb/tb_top.sv
